// ===== rtl/assert_macros.svh =====
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define TPB_ASSERT_SAME(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("turtle plotter check failed");

// Next-cycle implication, disabled during reset.
`define TPB_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("turtle plotter check failed");

`endif

// ===== rtl/tpb_pkg.sv =====
`timescale 1ns / 1ps

package tpb_pkg;

  localparam int GRID_SIZE_DEF = 16;
  localparam int DUMP_MAX      = 16;

  // command codes
  localparam logic [2:0] OP_PEN_UP   = 3'd0;
  localparam logic [2:0] OP_PEN_DOWN = 3'd1;
  localparam logic [2:0] OP_TURN_R   = 3'd2;
  localparam logic [2:0] OP_TURN_L   = 3'd3;
  localparam logic [2:0] OP_MOVE     = 3'd4;
  localparam logic [2:0] OP_DUMP     = 3'd5;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MOVE,
    ST_MARK_RD,
    ST_MARK_WR,
    ST_DUMP,
    ST_DRAIN,
    ST_FINISH
  } state_t;

endpackage

// ===== rtl/turtle_plotter_bitmap_core.sv =====
`timescale 1ns / 1ps

// Channel   | Transfer when        | Signals
// ----------+----------------------+-------------------------------------------
// command   | start & !busy        | operation, stride
// result    | strobe (one cycle)   | row_bits, row_index, last, cursor_row,
//           |                      | cursor_col, heading, pen_is_down
//
// Pen and turn commands go through ST_FINISH to their result. A move goes
// through ST_MOVE and, with the pen down, ST_MARK_RD and ST_MARK_WR for each
// marked bitmap column (up to GRID_SIZE), since each is a read-modify-write of
// the single-port bitmap, and then through ST_FINISH. A dump gives
// min(GRID_SIZE,16) results on consecutive cycles, each read in ST_DUMP.
// rst is synchronous; per-column valid flops make the bitmap read as cleared.
// busy stays high until the final result of a command is loaded; results
// cannot be stalled.
module turtle_plotter_bitmap_core #(
  parameter int GRID_SIZE = tpb_pkg::GRID_SIZE_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [2:0]  operation,
  input  logic [6:0]  stride,
  output logic        busy,
  output logic        strobe,
  output logic [15:0] row_bits,
  output logic [3:0]  row_index,
  output logic        last,
  output logic [3:0]  cursor_row,
  output logic [3:0]  cursor_col,
  output logic [1:0]  heading,
  output logic        pen_is_down
);

  localparam int AW        = $clog2(GRID_SIZE);
  localparam int DUMP_ROWS = (GRID_SIZE < tpb_pkg::DUMP_MAX) ? GRID_SIZE : tpb_pkg::DUMP_MAX;
  localparam int SW        = ((AW > 7) ? AW : 7) + 2;
  localparam logic [AW-1:0] DUMP_LAST = AW'(DUMP_ROWS - 1);
  localparam logic [AW-1:0] COORD_MAX = AW'(GRID_SIZE - 1);

  tpb_pkg::state_t state, state_next;

  logic [AW-1:0] cur_x, cur_y;
  logic [1:0]    dir;
  logic          pen;
  logic [6:0]    stride_q;
  logic [AW-1:0] r_lo, r_hi, col, col_hi;

  logic [GRID_SIZE-1:0] mem [GRID_SIZE];
  logic [GRID_SIZE-1:0] vld;
  logic [GRID_SIZE-1:0] rd_data;
  logic                 rd_vld;
  logic [GRID_SIZE-1:0] rd_eff;
  logic [GRID_SIZE-1:0] mask;

  logic          pend;
  logic [AW-1:0] pend_idx;
  logic          pend_last;

  logic rd_en, wr_en;

  // move datapath
  logic [AW-1:0] mv;
  logic [SW-1:0] mv_ext, st_ext, sum;
  logic [AW-1:0] newc, nx, ny;
  logic          neg;

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      tpb_pkg::ST_IDLE: begin
        if (start) begin
          if (operation == tpb_pkg::OP_MOVE) begin
            state_next = tpb_pkg::ST_MOVE;
          end else if (operation == tpb_pkg::OP_DUMP) begin
            state_next = tpb_pkg::ST_DUMP;
          end else begin
            state_next = tpb_pkg::ST_FINISH;
          end
        end
      end
      tpb_pkg::ST_MOVE:    state_next = pen ? tpb_pkg::ST_MARK_RD : tpb_pkg::ST_FINISH;
      tpb_pkg::ST_MARK_RD: state_next = tpb_pkg::ST_MARK_WR;
      tpb_pkg::ST_MARK_WR: state_next = (col == col_hi) ? tpb_pkg::ST_FINISH
                                                        : tpb_pkg::ST_MARK_RD;
      tpb_pkg::ST_DUMP:    state_next = (col == DUMP_LAST) ? tpb_pkg::ST_DRAIN
                                                           : tpb_pkg::ST_DUMP;
      tpb_pkg::ST_DRAIN:   state_next = tpb_pkg::ST_IDLE;
      tpb_pkg::ST_FINISH:  state_next = tpb_pkg::ST_IDLE;
      default:             state_next = tpb_pkg::ST_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    busy  = 1'b1;
    rd_en = 1'b0;
    wr_en = 1'b0;
    unique case (state)
      tpb_pkg::ST_IDLE:    busy  = 1'b0;
      tpb_pkg::ST_MARK_RD: rd_en = 1'b1;
      tpb_pkg::ST_MARK_WR: wr_en = 1'b1;
      tpb_pkg::ST_DUMP:    rd_en = 1'b1;
      default: ;
    endcase
  end

  // single adder moves the coordinate along the heading, then clamps
  always_comb begin
    neg    = dir[1];
    mv     = dir[0] ? cur_y : cur_x;
    mv_ext = SW'(mv);
    st_ext = SW'(stride_q);
    sum    = mv_ext + (neg ? (~st_ext + SW'(1)) : st_ext);
    if (neg && sum[SW-1]) begin
      newc = '0;
    end else if (!neg && (sum >= SW'(GRID_SIZE))) begin
      newc = COORD_MAX;
    end else begin
      newc = sum[AW-1:0];
    end
    nx = dir[0] ? cur_x : newc;
    ny = dir[0] ? newc : cur_y;
  end

  always_comb begin
    for (int j = 0; j < GRID_SIZE; j++) begin
      mask[j] = (AW'(j) >= r_lo) && (AW'(j) <= r_hi);
    end
  end

  assign rd_eff = rd_vld ? rd_data : '0;

  // bitmap memory: entry c holds column c, bit r is row r
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[col] <= rd_eff | mask;
    end
    if (rd_en) begin
      rd_data <= mem[col];
      rd_vld  <= vld[col];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= tpb_pkg::ST_IDLE;
      cur_x  <= '0;
      cur_y  <= '0;
      dir    <= '0;
      pen    <= 1'b0;
      vld    <= '0;
      pend   <= 1'b0;
      strobe <= 1'b0;
    end else begin
      state  <= state_next;
      strobe <= 1'b0;
      pend   <= 1'b0;

      unique case (state)
        tpb_pkg::ST_IDLE: begin
          if (start) begin
            unique case (operation)
              tpb_pkg::OP_PEN_UP:   pen <= 1'b0;
              tpb_pkg::OP_PEN_DOWN: pen <= 1'b1;
              tpb_pkg::OP_TURN_R:   dir <= dir + 2'd1;
              tpb_pkg::OP_TURN_L:   dir <= dir - 2'd1;
              tpb_pkg::OP_MOVE:     stride_q <= stride;
              tpb_pkg::OP_DUMP:     col <= '0;
              default: ;
            endcase
          end
        end
        tpb_pkg::ST_MOVE: begin
          cur_x  <= nx;
          cur_y  <= ny;
          r_lo   <= (cur_x < nx) ? cur_x : nx;
          r_hi   <= (cur_x < nx) ? nx : cur_x;
          col    <= (cur_y < ny) ? cur_y : ny;
          col_hi <= (cur_y < ny) ? ny : cur_y;
        end
        tpb_pkg::ST_MARK_WR: begin
          vld[col] <= 1'b1;
          if (col != col_hi) begin
            col <= col + AW'(1);
          end
        end
        tpb_pkg::ST_DUMP: begin
          pend      <= 1'b1;
          pend_idx  <= col;
          pend_last <= (col == DUMP_LAST);
          if (col != DUMP_LAST) begin
            col <= col + AW'(1);
          end
        end
        default: ;
      endcase

      if (state == tpb_pkg::ST_FINISH) begin
        strobe    <= 1'b1;
        row_bits  <= '0;
        row_index <= '0;
        last      <= 1'b1;
      end else if (pend) begin
        strobe    <= 1'b1;
        row_bits  <= 16'(rd_eff);
        row_index <= 4'(pend_idx);
        last      <= pend_last;
      end
      cursor_row  <= 4'(cur_x);
      cursor_col  <= 4'(cur_y);
      heading     <= dir;
      pen_is_down <= pen;
    end
  end

endmodule

// ===== rtl/tpb_checker.sv =====
`timescale 1ns / 1ps
`include "assert_macros.svh"

module tpb_checker (
  input logic       clk,
  input logic       rst,
  input logic       start,
  input logic       busy,
  input logic       strobe,
  input logic       last,
  input logic [3:0] row_index
);

  // an accepted command holds the block busy until its final result
  `TPB_ASSERT_NEXT(a_accept_busy, clk, rst, start && !busy, busy)
  `TPB_ASSERT_SAME(a_mid_busy, clk, rst, strobe && !last, busy)
  `TPB_ASSERT_SAME(a_last_free, clk, rst, strobe && last, !busy)
  // dump rows come back to back, in order
  `TPB_ASSERT_NEXT(a_rows_seq, clk, rst, strobe && !last,
                   strobe && (row_index == $past(row_index) + 4'd1))

endmodule

bind turtle_plotter_bitmap_core tpb_checker u_tpb_checker (
  .clk       (clk),
  .rst       (rst),
  .start     (start),
  .busy      (busy),
  .strobe    (strobe),
  .last      (last),
  .row_index (row_index)
);

// ===== sim/turtle_plotter_bitmap_core_tb.sv =====
`timescale 1ns / 1ps

module turtle_plotter_bitmap_core_tb;

  localparam int          CYCLE_LIMIT = 300000;
  localparam int          GRID        = tpb_pkg::GRID_SIZE_DEF;
  localparam logic [2:0]  OP_SPARE_6  = 3'd6;
  localparam logic [2:0]  OP_SPARE_7  = 3'd7;
  localparam logic [1:0]  HEAD_POS_ROW = 2'd0;
  localparam logic [1:0]  HEAD_POS_COL = 2'd1;
  localparam logic [1:0]  HEAD_NEG_ROW = 2'd2;
  localparam logic [1:0]  HEAD_NEG_COL = 2'd3;

  typedef struct packed {
    logic [15:0] row_bits;
    logic [3:0]  row_index;
    logic        last;
    logic [3:0]  cursor_row;
    logic [3:0]  cursor_col;
    logic [1:0]  heading;
    logic        pen_is_down;
  } plot_result_t;

  class plot_scoreboard;
    logic [15:0]  plot_cols[GRID];  // plot_cols[c] bit r marks cell (r, c)
    logic [3:0]   cur_row;
    logic [3:0]   cur_col;
    logic [1:0]   cur_head;
    logic         pen;
    plot_result_t expected_q[$];
    int           mismatches;

    function new();
      foreach (plot_cols[i]) plot_cols[i] = '0;
      cur_row    = '0;
      cur_col    = '0;
      cur_head   = HEAD_POS_ROW;
      pen        = 1'b0;
      mismatches = 0;
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    function int clamp_coord(int v);
      if (v < 0) return 0;
      if (v >= GRID) return GRID - 1;
      return v;
    endfunction

    function void push_result(logic [15:0] bits, logic [3:0] idx, logic lst);
      plot_result_t r;
      r.row_bits    = bits;
      r.row_index   = idx;
      r.last        = lst;
      r.cursor_row  = cur_row;
      r.cursor_col  = cur_col;
      r.heading     = cur_head;
      r.pen_is_down = pen;
      expected_q.push_back(r);
    endfunction

    function void apply_move(int steps);
      int dr;
      int dc;
      int nr;
      int nc;
      int r_lo;
      int r_hi;
      int c_lo;
      int c_hi;
      dr = 0;
      dc = 0;
      case (cur_head)
        HEAD_POS_ROW: dr = 1;
        HEAD_POS_COL: dc = 1;
        HEAD_NEG_ROW: dr = -1;
        HEAD_NEG_COL: dc = -1;
        default: ;
      endcase
      nr = clamp_coord(int'(cur_row) + dr * steps);
      nc = clamp_coord(int'(cur_col) + dc * steps);
      if (pen) begin
        r_lo = (nr < int'(cur_row)) ? nr : int'(cur_row);
        r_hi = (nr < int'(cur_row)) ? int'(cur_row) : nr;
        c_lo = (nc < int'(cur_col)) ? nc : int'(cur_col);
        c_hi = (nc < int'(cur_col)) ? int'(cur_col) : nc;
        for (int c = c_lo; c <= c_hi; c++)
          for (int r = r_lo; r <= r_hi; r++)
            plot_cols[c][r] = 1'b1;
      end
      cur_row = nr[3:0];
      cur_col = nc[3:0];
    endfunction

    function void note_command(logic [2:0] op, logic [6:0] steps);
      case (op)
        tpb_pkg::OP_PEN_UP:   pen = 1'b0;
        tpb_pkg::OP_PEN_DOWN: pen = 1'b1;
        tpb_pkg::OP_TURN_R:   cur_head = cur_head + 2'd1;
        tpb_pkg::OP_TURN_L:   cur_head = cur_head - 2'd1;
        tpb_pkg::OP_MOVE:     apply_move(int'(steps));
        default: ;
      endcase
      if (op == tpb_pkg::OP_DUMP) begin
        for (int i = 0; i < tpb_pkg::DUMP_MAX; i++)
          push_result(plot_cols[i], i[3:0], i == tpb_pkg::DUMP_MAX - 1);
      end else begin
        push_result('0, '0, 1'b1);
      end
    endfunction

    function void compare_field(string name, int unsigned exp_v, int unsigned got_v);
      if (exp_v != got_v) begin
        $error("%s: expected 0x%0h, got 0x%0h", name, exp_v, got_v);
        mismatches++;
      end
    endfunction

    function void check_result(plot_result_t got);
      plot_result_t exp_r;
      if (expected_q.size() == 0) begin
        $error("result strobe with nothing outstanding: row_bits 0x%0h row_index %0d",
               got.row_bits, got.row_index);
        mismatches++;
        return;
      end
      exp_r = expected_q.pop_front();
      compare_field("row_bits",    exp_r.row_bits,    got.row_bits);
      compare_field("row_index",   exp_r.row_index,   got.row_index);
      compare_field("last",        exp_r.last,        got.last);
      compare_field("cursor_row",  exp_r.cursor_row,  got.cursor_row);
      compare_field("cursor_col",  exp_r.cursor_col,  got.cursor_col);
      compare_field("heading",     exp_r.heading,     got.heading);
      compare_field("pen_is_down", exp_r.pen_is_down, got.pen_is_down);
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        start = 1'b0;
  logic [2:0]  operation = tpb_pkg::OP_PEN_UP;
  logic [6:0]  stride = '0;
  logic        busy;
  logic        strobe;
  logic [15:0] row_bits;
  logic [3:0]  row_index;
  logic        last;
  logic [3:0]  cursor_row;
  logic [3:0]  cursor_col;
  logic [1:0]  heading;
  logic        pen_is_down;

  plot_scoreboard sb;
  int unsigned    cycle_count = 0;

  turtle_plotter_bitmap_core dut (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .operation   (operation),
    .stride      (stride),
    .busy        (busy),
    .strobe      (strobe),
    .row_bits    (row_bits),
    .row_index   (row_index),
    .last        (last),
    .cursor_row  (cursor_row),
    .cursor_col  (cursor_col),
    .heading     (heading),
    .pen_is_down (pen_is_down)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // results are checked before a transfer at the same edge is noted
  always @(posedge clk) begin
    if (!rst) begin
      if (strobe)
        sb.check_result({row_bits, row_index, last, cursor_row, cursor_col,
                         heading, pen_is_down});
      if (start && !busy)
        sb.note_command(operation, stride);
    end
  end

  // call right after a rising edge; returns at the edge of the transfer, or after a random idle gap that follows it
  task automatic send_command(input logic [2:0] op, input logic [6:0] steps,
                              input int idle_pct);
    int gap;
    start     <= 1'b1;
    operation <= op;
    stride    <= steps;
    @(posedge clk);
    while (busy) @(posedge clk);
    if (idle_pct > 0 && $urandom_range(0, 99) < idle_pct) begin
      gap = $urandom_range(1, 30);
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic drain_results();
    start <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
  endtask

  function automatic logic [2:0] pick_operation();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 45) return tpb_pkg::OP_MOVE;
    if (roll < 57) return tpb_pkg::OP_PEN_DOWN;
    if (roll < 65) return tpb_pkg::OP_PEN_UP;
    if (roll < 77) return tpb_pkg::OP_TURN_R;
    if (roll < 89) return tpb_pkg::OP_TURN_L;
    if (roll < 97) return tpb_pkg::OP_DUMP;
    return ($urandom_range(0, 1) == 0) ? OP_SPARE_6 : OP_SPARE_7;
  endfunction

  function automatic logic [6:0] pick_stride();
    if ($urandom_range(0, 99) < 70) return 7'($urandom_range(0, 15));
    return 7'($urandom_range(0, 99));
  endfunction

  initial begin
    int idle_pct[4];
    sb = new();
    idle_pct = '{0, 55, 0, 25};
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // walk the edges and corners, wrap the heading both ways
    send_command(tpb_pkg::OP_DUMP,     7'd0,  0);  // empty bitmap
    send_command(OP_SPARE_6,           7'd99, 0);
    send_command(OP_SPARE_7,           7'd28, 0);
    send_command(tpb_pkg::OP_PEN_DOWN, 7'd0,  0);
    send_command(tpb_pkg::OP_MOVE,     7'd0,  0);  // zero stride marks the current cell
    send_command(tpb_pkg::OP_MOVE,     7'd99, 0);  // saturates at the far row
    send_command(tpb_pkg::OP_TURN_L,   7'd0,  0);  // wraps below zero
    send_command(tpb_pkg::OP_MOVE,     7'd3,  0);  // saturates at column zero
    send_command(tpb_pkg::OP_TURN_R,   7'd0,  0);
    send_command(tpb_pkg::OP_TURN_R,   7'd0,  0);
    send_command(tpb_pkg::OP_MOVE,     7'd99, 0);
    send_command(tpb_pkg::OP_TURN_R,   7'd0,  0);
    send_command(tpb_pkg::OP_MOVE,     7'd28, 0);
    send_command(tpb_pkg::OP_TURN_R,   7'd0,  0);
    send_command(tpb_pkg::OP_PEN_UP,   7'd0,  0);
    send_command(tpb_pkg::OP_MOVE,     7'd7,  0);
    send_command(tpb_pkg::OP_TURN_L,   7'd0,  0);
    send_command(tpb_pkg::OP_PEN_DOWN, 7'd0,  0);
    send_command(tpb_pkg::OP_MOVE,     7'd1,  0);
    send_command(tpb_pkg::OP_TURN_R,   7'd0,  0);
    send_command(tpb_pkg::OP_TURN_R,   7'd0,  0);  // wraps past three
    send_command(tpb_pkg::OP_MOVE,     7'd4,  0);
    send_command(tpb_pkg::OP_DUMP,     7'd99, 0);
    send_command(tpb_pkg::OP_PEN_UP,   7'd0,  0);
    send_command(tpb_pkg::OP_DUMP,     7'd0,  0);
    drain_results();
    @(posedge clk);

    for (int ph = 0; ph < 4; ph++) begin
      for (int n = 0; n < 62; n++)
        send_command(pick_operation(), pick_stride(), idle_pct[ph]);
    end

    drain_results();
    repeat (50) @(posedge clk);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
